[rtl/core/bpl_pkg.sv]
// Shared types, codes and helpers for the bilinear plasticity material point.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package bpl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Rounding offsets for the two fixed-point shifts used by the datapath
  localparam logic [71:0] RND26 = 72'h2000000;
  localparam logic [71:0] RND16 = 72'h8000;

  localparam logic [31:0] RST_ELASTIC    = 32'd3200000;
  localparam logic [30:0] RST_YIELD      = 31'd102400;
  localparam logic [15:0] RST_HARDENING  = 16'd3277;
  localparam logic [15:0] RST_KINEMATIC  = 16'd0;
  localparam logic [31:0] RST_PLASTIC    = 32'd168421;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELASTIC   = 3'd0,
    REG_YIELD     = 3'd1,
    REG_HARDENING = 3'd2,
    REG_KINEMATIC = 3'd3,
    REG_PLASTIC   = 3'd4
  } bpl_reg_t;

  typedef enum logic [1:0] {
    CMD_TRIAL  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_REVERT = 2'd2,
    CMD_CLEAR  = 2'd3
  } bpl_code_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CMD,
    ST_DE,
    ST_PRED,
    ST_ISO_A,
    ST_ISO_B,
    ST_ISO_C,
    ST_YIELD,
    ST_DIV_INIT,
    ST_DIV,
    ST_CORR,
    ST_BACK_A,
    ST_BACK_B,
    ST_BACK_C,
    ST_BACK_D,
    ST_TAN,
    ST_OUT
  } bpl_state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CMD,
    OP_DE,
    OP_PRED,
    OP_ISO_A,
    OP_ISO_B,
    OP_ISO_C,
    OP_YIELD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_CORR,
    OP_BACK_A,
    OP_BACK_B,
    OP_BACK_C,
    OP_BACK_D,
    OP_TAN,
    OP_OUT
  } bpl_op_t;

  typedef struct packed {
    logic        upd;       // trial update with a nonzero increment
    logic        plastic;   // shifted stress lies outside the yield surface
    logic        div_sat;   // plastic increment saturates, skip the divider
    logic        out_free;  // output register can take a result this cycle
  } bpl_stat_t;

  typedef struct packed {
    logic [31:0] young_mod;
    logic [30:0] yield_limit;
    logic [15:0] tan_ratio;
    logic [15:0] kinematic_share;
    logic [31:0] hard_mod;
  } bpl_cfg_t;

  // Saturate a wide two's complement value to signed 32 bits
  function automatic logic [31:0] sat32(input logic [41:0] v);
    logic [31:0] r;
    if ((v[41:31] == 11'h000) || (v[41:31] == 11'h7FF)) begin
      r = v[31:0];
    end else if (v[41]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bpl_if.sv]
// Valid/ready channel interfaces: request items, result items, register writes.
// Depends on bpl_pkg for the register index width.
`timescale 1ns / 1ps
`default_nettype none

interface bpl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] total_strain;

  modport source (output valid, output cmd, output total_strain, input ready);
  modport sink (input valid, input cmd, input total_strain, output ready);
endinterface

interface bpl_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] stress_out;
  logic [31:0] tangent_stiffness;
  logic        yielding;

  modport source (output valid, output stress_out, output tangent_stiffness,
                  output yielding, input ready);
  modport sink (input valid, input stress_out, input tangent_stiffness,
                input yielding, output ready);
endinterface

interface bpl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpl_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/bilinear_plasticity_1d_top.sv]
// Commit, revert, clear or a zero strain increment go straight to tangent and output;
// an elastic trial update first forms the predictor and checks yield; a plastic one
// also runs the restoring divider (unless its increment saturates) and the correction.
// One transaction in flight; the next is taken only after its result is registered.
// Reset zeroes all material state and loads register defaults at once.
// Top level: config registers, sequencer and datapath. Uses bpl_pkg, bpl_if,
// bpl_ctrl and bpl_dp.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_plasticity_1d_top (
  input  wire             clk,
  input  wire             rst,
  bpl_req_if.sink         req,
  bpl_rsp_if.source       rsp,
  bpl_cfg_if.sink         cfg
);

  bpl_pkg::bpl_cfg_t  regs;
  bpl_pkg::bpl_stat_t stat;
  bpl_pkg::bpl_op_t   op;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.young_mod       <= bpl_pkg::RST_ELASTIC;
      regs.yield_limit     <= bpl_pkg::RST_YIELD;
      regs.tan_ratio       <= bpl_pkg::RST_HARDENING;
      regs.kinematic_share <= bpl_pkg::RST_KINEMATIC;
      regs.hard_mod        <= bpl_pkg::RST_PLASTIC;
    end else if (cfg.valid) begin
      case (cfg.index)
        bpl_pkg::REG_ELASTIC:   regs.young_mod       <= cfg.data;
        bpl_pkg::REG_YIELD:     regs.yield_limit     <= cfg.data[30:0];
        bpl_pkg::REG_HARDENING: regs.tan_ratio       <= cfg.data[15:0];
        bpl_pkg::REG_KINEMATIC: regs.kinematic_share <= cfg.data[15:0];
        bpl_pkg::REG_PLASTIC:   regs.hard_mod        <= cfg.data;
        default: ;
      endcase
    end
  end

  bpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .op        (op)
  );

  bpl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .cfg          (regs),
    .req_cmd      (req.cmd),
    .req_strain   (req.total_strain),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .out_stress   (rsp.stress_out),
    .out_tangent  (rsp.tangent_stiffness),
    .out_yielding (rsp.yielding),
    .stat         (stat)
  );

endmodule

`default_nettype wire

[rtl/core/bpl_ctrl.sv]
// Sequencer for the return-mapping update: one datapath op per cycle, except
// in idle or an output stall. Uses bpl_pkg states, ops and status struct.
`timescale 1ns / 1ps
`default_nettype none

module bpl_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  bpl_pkg::bpl_stat_t    stat,
  output bpl_pkg::bpl_op_t      op
);

  bpl_pkg::bpl_state_t state;
  bpl_pkg::bpl_state_t state_next;
  logic [bpl_pkg::DIV_CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpl_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == bpl_pkg::ST_DIV_INIT) begin
        cnt <= bpl_pkg::DIV_LAST;
      end else if (state == bpl_pkg::ST_DIV) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bpl_pkg::ST_IDLE:     if (req_valid) state_next = bpl_pkg::ST_CMD;
      bpl_pkg::ST_CMD:      state_next = stat.upd ? bpl_pkg::ST_DE : bpl_pkg::ST_TAN;
      bpl_pkg::ST_DE:       state_next = bpl_pkg::ST_PRED;
      bpl_pkg::ST_PRED:     state_next = bpl_pkg::ST_ISO_A;
      bpl_pkg::ST_ISO_A:    state_next = bpl_pkg::ST_ISO_B;
      bpl_pkg::ST_ISO_B:    state_next = bpl_pkg::ST_ISO_C;
      bpl_pkg::ST_ISO_C:    state_next = bpl_pkg::ST_YIELD;
      bpl_pkg::ST_YIELD:    state_next = stat.plastic ? bpl_pkg::ST_DIV_INIT : bpl_pkg::ST_TAN;
      bpl_pkg::ST_DIV_INIT: state_next = stat.div_sat ? bpl_pkg::ST_CORR : bpl_pkg::ST_DIV;
      bpl_pkg::ST_DIV:      if (cnt == '0) state_next = bpl_pkg::ST_CORR;
      bpl_pkg::ST_CORR:     state_next = bpl_pkg::ST_BACK_A;
      bpl_pkg::ST_BACK_A:   state_next = bpl_pkg::ST_BACK_B;
      bpl_pkg::ST_BACK_B:   state_next = bpl_pkg::ST_BACK_C;
      bpl_pkg::ST_BACK_C:   state_next = bpl_pkg::ST_BACK_D;
      bpl_pkg::ST_BACK_D:   state_next = bpl_pkg::ST_TAN;
      bpl_pkg::ST_TAN:      state_next = bpl_pkg::ST_OUT;
      bpl_pkg::ST_OUT:      if (stat.out_free) state_next = bpl_pkg::ST_IDLE;
      default:              state_next = bpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    op        = bpl_pkg::OP_NOP;
    case (state)
      bpl_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) op = bpl_pkg::OP_LOAD;
      end
      bpl_pkg::ST_CMD:      op = bpl_pkg::OP_CMD;
      bpl_pkg::ST_DE:       op = bpl_pkg::OP_DE;
      bpl_pkg::ST_PRED:     op = bpl_pkg::OP_PRED;
      bpl_pkg::ST_ISO_A:    op = bpl_pkg::OP_ISO_A;
      bpl_pkg::ST_ISO_B:    op = bpl_pkg::OP_ISO_B;
      bpl_pkg::ST_ISO_C:    op = bpl_pkg::OP_ISO_C;
      bpl_pkg::ST_YIELD:    op = bpl_pkg::OP_YIELD;
      bpl_pkg::ST_DIV_INIT: op = bpl_pkg::OP_DIV_INIT;
      bpl_pkg::ST_DIV:      op = bpl_pkg::OP_DIV_STEP;
      bpl_pkg::ST_CORR:     op = bpl_pkg::OP_CORR;
      bpl_pkg::ST_BACK_A:   op = bpl_pkg::OP_BACK_A;
      bpl_pkg::ST_BACK_B:   op = bpl_pkg::OP_BACK_B;
      bpl_pkg::ST_BACK_C:   op = bpl_pkg::OP_BACK_C;
      bpl_pkg::ST_BACK_D:   op = bpl_pkg::OP_BACK_D;
      bpl_pkg::ST_TAN:      op = bpl_pkg::OP_TAN;
      bpl_pkg::ST_OUT:      if (stat.out_free) op = bpl_pkg::OP_OUT;
      default:              op = bpl_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/bpl_dp.sv]
// Datapath: committed/trial state, shared multiplier, restoring divider and
// the output register. Driven one op per cycle by bpl_ctrl; uses bpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpl_dp (
  input  wire                   clk,
  input  wire                   rst,
  input  bpl_pkg::bpl_op_t      op,
  input  bpl_pkg::bpl_cfg_t     cfg,
  input  logic [1:0]            req_cmd,
  input  logic [31:0]           req_strain,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [31:0]           out_stress,
  output logic [31:0]           out_tangent,
  output logic                  out_yielding,
  output bpl_pkg::bpl_stat_t    stat
);

  bpl_pkg::bpl_code_t cmd_r;
  logic [31:0] strain_r;

  logic [31:0] c_strain, c_stress, c_back, c_ep;
  logic        c_flag;
  logic [31:0] tr_strain, t_stress, t_back, t_ep;
  logic        t_flag;

  logic [32:0] mag;
  logic        d_neg;
  logic [32:0] den;
  logic [71:0] prod;
  logic [38:0] tmp;
  logic [41:0] pred, xi, absxi, lim, f;
  logic        xi_neg;
  logic [31:0] q;
  logic [32:0] rem;
  logic [31:0] nlow;

  logic [32:0] diff, diff_abs;
  logic [71:0] r26_sum, r16_sum;
  logic [38:0] r26;
  logic [39:0] r16;
  logic [38:0] mul_a;
  logic [32:0] mul_b;
  logic [71:0] mul_p;
  logic [41:0] cs_ext, tb_ext, r26_ext, r16_ext;
  logic [32:0] ep_sum;
  logic [33:0] r2, r2_sub;
  logic        ge;
  logic [16:0] iso_share;

  assign diff     = {strain_r[31], strain_r} - {c_strain[31], c_strain};
  assign diff_abs = diff[32] ? (33'd0 - diff) : diff;

  assign r26_sum = prod + bpl_pkg::RND26;
  assign r16_sum = prod + bpl_pkg::RND16;
  assign r26     = r26_sum[64:26];
  assign r16     = r16_sum[55:16];

  assign cs_ext  = {{10{c_stress[31]}}, c_stress};
  assign tb_ext  = {{10{t_back[31]}}, t_back};
  assign r26_ext = {3'd0, r26};
  assign r16_ext = {2'd0, r16};
  assign ep_sum  = {1'b0, t_ep} + {1'b0, q};

  assign iso_share = 17'h10000 - {1'b0, cfg.kinematic_share};

  assign r2     = {rem, nlow[31]};
  assign r2_sub = r2 - {1'b0, den};
  assign ge     = (r2 >= {1'b0, den});

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      bpl_pkg::OP_DE: begin
        mul_a = {7'd0, cfg.young_mod};
        mul_b = mag;
      end
      bpl_pkg::OP_PRED: begin
        mul_a = {7'd0, cfg.hard_mod};
        mul_b = {1'b0, t_ep};
      end
      bpl_pkg::OP_ISO_B: begin
        mul_a = tmp;
        mul_b = {16'd0, iso_share};
      end
      bpl_pkg::OP_CORR: begin
        mul_a = {7'd0, cfg.young_mod};
        mul_b = {1'b0, q};
      end
      bpl_pkg::OP_BACK_A: begin
        mul_a = {7'd0, cfg.hard_mod};
        mul_b = {1'b0, q};
      end
      bpl_pkg::OP_BACK_C: begin
        mul_a = tmp;
        mul_b = {17'd0, cfg.kinematic_share};
      end
      bpl_pkg::OP_TAN: begin
        mul_a = {7'd0, cfg.young_mod};
        mul_b = {17'd0, cfg.tan_ratio};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {33'd0, mul_a} * {39'd0, mul_b};

  always_comb begin
    stat.upd      = (cmd_r == bpl_pkg::CMD_TRIAL) && (diff != '0);
    stat.plastic  = (absxi > lim);
    stat.div_sat  = (f >= {3'd0, den, 6'd0});
    stat.out_free = !out_valid || out_ready;
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      c_strain  <= '0;
      c_stress  <= '0;
      c_back    <= '0;
      c_ep      <= '0;
      c_flag    <= 1'b0;
      tr_strain <= '0;
      t_stress  <= '0;
      t_back    <= '0;
      t_ep      <= '0;
      t_flag    <= 1'b0;
      cmd_r     <= bpl_pkg::CMD_TRIAL;
    end else begin
      case (op)
        bpl_pkg::OP_LOAD: begin
          cmd_r <= bpl_pkg::bpl_code_t'(req_cmd);
        end
        bpl_pkg::OP_CMD: begin
          case (cmd_r)
            bpl_pkg::CMD_TRIAL: begin
              tr_strain <= strain_r;
              if (diff != '0) begin
                t_back <= c_back;
                t_ep   <= c_ep;
                t_flag <= 1'b0;
              end
            end
            bpl_pkg::CMD_COMMIT: begin
              c_strain <= tr_strain;
              c_stress <= t_stress;
              c_back   <= t_back;
              c_ep     <= t_ep;
              c_flag   <= t_flag;
            end
            bpl_pkg::CMD_REVERT: begin
              tr_strain <= c_strain;
              t_stress  <= c_stress;
              t_back    <= c_back;
              t_ep      <= c_ep;
              t_flag    <= c_flag;
            end
            bpl_pkg::CMD_CLEAR: begin
              c_strain  <= '0;
              c_stress  <= '0;
              c_back    <= '0;
              c_ep      <= '0;
              c_flag    <= 1'b0;
              tr_strain <= '0;
              t_stress  <= '0;
              t_back    <= '0;
              t_ep      <= '0;
              t_flag    <= 1'b0;
            end
            default: ;
          endcase
        end
        bpl_pkg::OP_YIELD: begin
          if (!(absxi > lim)) t_stress <= bpl_pkg::sat32(pred);
        end
        bpl_pkg::OP_BACK_A: begin
          t_ep <= ep_sum[32] ? 32'hFFFF_FFFF : ep_sum[31:0];
        end
        bpl_pkg::OP_BACK_D: begin
          t_back   <= bpl_pkg::sat32(xi_neg ? (tb_ext - r16_ext) : (tb_ext + r16_ext));
          t_stress <= bpl_pkg::sat32(pred);
          t_flag   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (op)
      bpl_pkg::OP_LOAD: begin
        strain_r <= req_strain;
      end
      bpl_pkg::OP_CMD: begin
        mag   <= diff_abs;
        d_neg <= diff[32];
        den   <= {1'b0, cfg.young_mod} + {1'b0, cfg.hard_mod};
      end
      bpl_pkg::OP_DE: begin
        prod <= mul_p;
      end
      bpl_pkg::OP_PRED: begin
        pred <= d_neg ? (cs_ext - r26_ext) : (cs_ext + r26_ext);
        prod <= mul_p;
      end
      bpl_pkg::OP_ISO_A: begin
        tmp <= r26;
        xi  <= pred - tb_ext;
      end
      bpl_pkg::OP_ISO_B: begin
        prod   <= mul_p;
        absxi  <= xi[41] ? (42'd0 - xi) : xi;
        xi_neg <= xi[41];
      end
      bpl_pkg::OP_ISO_C: begin
        lim <= {11'd0, cfg.yield_limit} + r16_ext;
      end
      bpl_pkg::OP_YIELD: begin
        f <= absxi - lim;
      end
      bpl_pkg::OP_DIV_INIT: begin
        // quotient below 2^32 is guaranteed unless saturating
        q    <= stat.div_sat ? 32'hFFFF_FFFF : 32'd0;
        rem  <= f[38:6];
        nlow <= {f[5:0], 26'd0};
      end
      bpl_pkg::OP_DIV_STEP: begin
        rem  <= ge ? r2_sub[32:0] : r2[32:0];
        q    <= {q[30:0], ge};
        nlow <= {nlow[30:0], 1'b0};
      end
      bpl_pkg::OP_CORR: begin
        prod <= mul_p;
      end
      bpl_pkg::OP_BACK_A: begin
        pred <= xi_neg ? (pred + r26_ext) : (pred - r26_ext);
        prod <= mul_p;
      end
      bpl_pkg::OP_BACK_B: begin
        tmp <= r26;
      end
      bpl_pkg::OP_BACK_C: begin
        prod <= mul_p;
      end
      bpl_pkg::OP_TAN: begin
        prod <= mul_p;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == bpl_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == bpl_pkg::OP_OUT) begin
      out_stress   <= t_stress;
      out_tangent  <= t_flag ? r16[31:0] : cfg.young_mod;
      out_yielding <= t_flag;
    end
  end

endmodule

`default_nettype wire
